// ===== rtl/pbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types and constants for the packet buffer placement block.
// ----------------------------------------------------------------------------
package pbp_pkg;

    localparam int ALU_W = 50;

    localparam logic [2:0] ACT_CUR   = 3'd0;
    localparam logic [2:0] ACT_OVF   = 3'd1;
    localparam logic [2:0] ACT_LATE  = 3'd2;
    localparam logic [2:0] ACT_CLOSE = 3'd3;
    localparam logic [2:0] ACT_FAR   = 3'd4;

    localparam logic [1:0] CFG_BUF_BYTES = 2'd0;
    localparam logic [1:0] CFG_OVF_BYTES = 2'd1;
    localparam logic [1:0] CFG_STR_OFS   = 2'd2;

    localparam logic [32:0] BUF_BYTES_RST = 33'd1048576;
    localparam logic [24:0] OVF_BYTES_RST = 25'd8192;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DONE,
        ST_OFS,
        ST_END,
        ST_OVE,
        ST_C0,
        ST_C1,
        ST_C2,
        ST_DEC,
        ST_CUR,
        ST_OV1,
        ST_OV2,
        ST_OV3,
        ST_CHK,
        ST_EMIT,
        ST_CL0,
        ST_CL1,
        ST_CL2
    } t_state;

    typedef enum logic [1:0] {
        RET_LOOP,
        RET_END,
        RET_STOP
    } t_ret;

    typedef struct packed {
        logic [32:0] buf_bytes;
        logic [24:0] ovf_bytes;
        logic [23:0] str_ofs;
    } t_cfg;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] write_offset;
        logic [31:0] buffer_index;
        logic [31:0] drop_count;
        logic [24:0] carried_bytes;
        logic        last;
    } t_res;

endpackage

// ===== rtl/pbp_alu.sv =====
// ----------------------------------------------------------------------------
// pbp_alu
// Shared add / subtract unit; subtract also reports a borrow for compares.
// ----------------------------------------------------------------------------
module pbp_alu
    import pbp_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W:0] sum;

    assign sum = {1'b0, i_req.a} + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
               + {{ALU_W{1'b0}}, i_req.sub};

    assign o_rsp.res    = sum[ALU_W-1:0];
    assign o_rsp.borrow = i_req.sub & ~sum[ALU_W];

endmodule

// ===== rtl/pbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbp_ctrl
// Sequencer, placement state and result register around the shared unit.
// ----------------------------------------------------------------------------
module pbp_ctrl
    import pbp_pkg::*;
#(
    parameter int MAX_ADVANCE = 4
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_in_cmd,
    input  logic [47:0] i_in_ofs,
    input  logic [15:0] i_in_bytes,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_res     o_out,
    output t_alu_req o_alu_req,
    input  t_alu_rsp i_alu_rsp
);

    localparam int ADV_W = $clog2(MAX_ADVANCE + 1);

    t_state r_state, n_state;
    t_ret   r_ret;

    logic [47:0] r_boff;
    logic [15:0] r_pb;
    logic [48:0] r_off;
    logic [48:0] r_end;
    logic [49:0] r_ove;
    logic        r_lt0, r_lt1, r_lt2;
    logic [31:0] r_wofs;
    logic [24:0] r_rel;
    logic [24:0] r_ext;
    logic [2:0]  r_act;
    logic        r_close;
    logic [31:0] r_drop;
    logic [ADV_W-1:0] r_adv;

    logic [47:0] r_start;
    logic [32:0] r_bib;
    logic [24:0] r_ovx;
    logic [32:0] r_ocnt;
    logic [31:0] r_bcnt;
    logic        r_stopped;

    logic r_ovalid;
    t_res r_out;

    logic        accept;
    logic        out_free;
    logic        in_cur, in_ov, far_max;
    logic        emit;
    t_res        emit_res;
    logic [31:0] half;
    logic [31:0] place_wofs;

    assign half     = i_cfg.buf_bytes[32:1];
    assign out_free = !r_ovalid || i_out_ready;
    assign accept   = i_in_valid && o_in_ready;
    assign in_cur   = !r_lt0 && r_lt1;
    assign in_ov    = !r_lt1 && r_lt2;
    assign far_max  = (r_adv >= ADV_W'(MAX_ADVANCE));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_stopped) begin
                        n_state = ST_DONE;
                    end else if (i_in_cmd) begin
                        n_state = ST_CL0;
                    end else begin
                        n_state = ST_OFS;
                    end
                end
            end
            ST_DONE: n_state = ST_IDLE;
            ST_OFS:  n_state = ST_END;
            ST_END:  n_state = ST_OVE;
            ST_OVE:  n_state = ST_C0;
            ST_C0:   n_state = ST_C1;
            ST_C1:   n_state = ST_C2;
            ST_C2:   n_state = ST_DEC;
            ST_DEC: begin
                if (in_cur) begin
                    n_state = ST_CUR;
                end else if (in_ov) begin
                    n_state = ST_OV1;
                end else if (r_lt0) begin
                    n_state = ST_CHK;
                end else if (!far_max) begin
                    n_state = ST_CL0;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CUR:  n_state = ST_CHK;
            ST_OV1:  n_state = ST_OV2;
            ST_OV2:  n_state = ST_OV3;
            ST_OV3:  n_state = ST_CHK;
            ST_CHK:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = r_close ? ST_CL0 : ST_IDLE;
                end
            end
            ST_CL0:  n_state = ST_CL1;
            ST_CL1: begin
                if (out_free) begin
                    n_state = ST_CL2;
                end
            end
            ST_CL2:  n_state = (r_ret == RET_LOOP) ? ST_END : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_act)
            ACT_CUR: place_wofs = r_wofs;
            ACT_OVF: place_wofs = {7'd0, r_rel};
            default: place_wofs = 32'd0;
        endcase
    end

    // outputs: shared unit operands and result emission
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_alu_req  = '0;
        emit       = 1'b0;
        emit_res   = '0;
        emit_res.buffer_index = r_bcnt;
        case (r_state)
            ST_OFS: begin
                o_alu_req.a = {2'd0, r_boff};
                o_alu_req.b = {26'd0, i_cfg.str_ofs};
            end
            ST_END, ST_CL2: begin
                o_alu_req.a = {2'd0, r_start};
                o_alu_req.b = {17'd0, i_cfg.buf_bytes};
            end
            ST_OVE: begin
                o_alu_req.a = {1'b0, r_end};
                o_alu_req.b = {25'd0, i_cfg.ovf_bytes};
            end
            ST_C0: begin
                o_alu_req.a   = {1'b0, r_off};
                o_alu_req.b   = {2'd0, r_start};
                o_alu_req.sub = 1'b1;
            end
            ST_C1: begin
                o_alu_req.a   = {1'b0, r_off};
                o_alu_req.b   = {1'b0, r_end};
                o_alu_req.sub = 1'b1;
            end
            ST_C2: begin
                o_alu_req.a   = {1'b0, r_off};
                o_alu_req.b   = r_ove;
                o_alu_req.sub = 1'b1;
            end
            ST_DEC: begin
                if (!in_cur && !in_ov && !r_lt0 && far_max && out_free) begin
                    emit            = 1'b1;
                    emit_res.action = ACT_FAR;
                    emit_res.last   = 1'b1;
                end
            end
            ST_CUR: begin
                o_alu_req.a = {17'd0, r_bib};
                o_alu_req.b = {34'd0, r_pb};
            end
            ST_OV1: begin
                o_alu_req.a = {25'd0, r_rel};
                o_alu_req.b = {34'd0, r_pb};
            end
            ST_OV2: begin
                o_alu_req.a   = {25'd0, r_ovx};
                o_alu_req.b   = {25'd0, r_ext};
                o_alu_req.sub = 1'b1;
            end
            ST_OV3: begin
                o_alu_req.a = {17'd0, r_ocnt};
                o_alu_req.b = {34'd0, r_pb};
            end
            ST_CHK: begin
                o_alu_req.a   = {17'd0, r_bib};
                o_alu_req.b   = {18'd0, half};
                o_alu_req.sub = 1'b1;
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit                  = 1'b1;
                    emit_res.action       = r_act;
                    emit_res.write_offset = place_wofs;
                    emit_res.last         = !r_close;
                end
            end
            ST_CL0: begin
                o_alu_req.a   = {18'd0, half};
                o_alu_req.b   = {17'd0, r_bib};
                o_alu_req.sub = 1'b1;
            end
            ST_CL1: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    emit_res.action        = ACT_CLOSE;
                    emit_res.drop_count    = r_drop;
                    emit_res.carried_bytes = r_ovx;
                    emit_res.last          = (r_ret != RET_LOOP);
                end
            end
            default: begin
                o_alu_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_start   <= '0;
            r_bib     <= '0;
            r_ovx     <= '0;
            r_ocnt    <= '0;
            r_bcnt    <= '0;
            r_stopped <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_OV2: begin
                    if (i_alu_rsp.borrow) begin
                        r_ovx <= r_ext;
                    end
                end
                ST_CUR: begin
                    r_bib <= (|i_alu_rsp.res[49:33]) ? '1 : i_alu_rsp.res[32:0];
                end
                ST_OV3: begin
                    r_ocnt <= (|i_alu_rsp.res[49:33]) ? '1 : i_alu_rsp.res[32:0];
                end
                ST_CL2: begin
                    r_start <= (|i_alu_rsp.res[49:48]) ? '1 : i_alu_rsp.res[47:0];
                    r_bcnt  <= r_bcnt + 32'd1;
                    r_bib   <= (r_ovx != '0) ? r_ocnt : '0;
                    r_ovx   <= '0;
                    r_ocnt  <= '0;
                    if (r_ret == RET_STOP) begin
                        r_stopped <= 1'b1;
                    end
                end
                default: begin
                    r_bcnt <= r_bcnt;
                end
            endcase
        end
    end

    // payload and scratch registers
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= emit_res;
        end
        case (r_state)
            ST_IDLE: begin
                r_boff <= i_in_ofs;
                r_pb   <= i_in_bytes;
                r_adv  <= '0;
                r_ret  <= RET_STOP;
            end
            ST_OFS: r_off <= i_alu_rsp.res[48:0];
            ST_END: r_end <= i_alu_rsp.res[48:0];
            ST_OVE: r_ove <= i_alu_rsp.res;
            ST_C0: begin
                r_lt0  <= i_alu_rsp.borrow;
                r_wofs <= i_alu_rsp.res[31:0];
            end
            ST_C1: begin
                r_lt1 <= i_alu_rsp.borrow;
                r_rel <= i_alu_rsp.res[24:0];
            end
            ST_C2: r_lt2 <= i_alu_rsp.borrow;
            ST_DEC: begin
                if (in_cur) begin
                    r_act <= ACT_CUR;
                end else if (in_ov) begin
                    r_act <= ACT_OVF;
                end else if (r_lt0) begin
                    r_act <= ACT_LATE;
                end else if (!far_max) begin
                    r_adv <= r_adv + ADV_W'(1);
                    r_ret <= RET_LOOP;
                end
            end
            ST_OV1: begin
                r_ext <= (|i_alu_rsp.res[49:25]) ? '1 : i_alu_rsp.res[24:0];
            end
            ST_CHK: r_close <= !i_alu_rsp.borrow;
            ST_EMIT: r_ret <= RET_END;
            ST_CL0: r_drop <= i_alu_rsp.borrow ? 32'd0 : i_alu_rsp.res[31:0];
            default: begin
                r_pb <= r_pb;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

// ===== rtl/packet_buffer_placement_top.sv =====
// ----------------------------------------------------------------------------
// packet_buffer_placement_top
// Places stream packets into the current buffer or overflow window, discards
// late packets and closes buffers on overrun, fill or end of stream.
//
//   channel   dir  handshake                    payload
//   s_axis    in   tvalid / tready              tdata: offset, bytes; tuser: cmd
//   m_axis    out  tvalid / tready              tdata: result fields; tuser: action
//   cfg       in   valid / ready                index, data
//
// a packet works through the shared adder in order: stream offset, buffer end,
// overflow end, three compares, decision, then the current or overflow sums and
// the fill check; each buffer close and each retry in the next buffer add steps
// an end of stream command closes the buffer, items after stop give no result
// the adder sequencer holds s_axis tready low until the item is done
// a stalled result holds the sequencer only when it has the next result ready
// synchronous active-low reset clears buffer, overflow and stream state, config to defaults
// ----------------------------------------------------------------------------
module packet_buffer_placement_top
    import pbp_pkg::*;
#(
    parameter int MAX_ADVANCE = 4
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // pkt_offset[47:0], packet_bytes[63:48]
    input  logic         i_s_axis_tuser,   // command[0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // write_offset[31:0], buffer_index[63:32],
                                           // drop_count[95:64], carried_bytes[120:96]
    output logic [2:0]   o_m_axis_tuser,   // action[2:0]
    output logic         o_m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [32:0]  i_cfg_data
);

    t_cfg     r_cfg;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    t_res     res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buf_bytes <= BUF_BYTES_RST;
            r_cfg.ovf_bytes <= OVF_BYTES_RST;
            r_cfg.str_ofs   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BUF_BYTES: r_cfg.buf_bytes <= i_cfg_data;
                CFG_OVF_BYTES: r_cfg.ovf_bytes <= i_cfg_data[24:0];
                CFG_STR_OFS:   r_cfg.str_ofs   <= i_cfg_data[23:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    pbp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    pbp_ctrl #(
        .MAX_ADVANCE (MAX_ADVANCE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_cmd    (i_s_axis_tuser),
        .i_in_ofs    (i_s_axis_tdata[47:0]),
        .i_in_bytes  (i_s_axis_tdata[63:48]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (res),
        .o_alu_req   (alu_req),
        .i_alu_rsp   (alu_rsp)
    );

    assign o_m_axis_tdata = {7'd0, res.carried_bytes, res.drop_count,
                             res.buffer_index, res.write_offset};
    assign o_m_axis_tuser = res.action;
    assign o_m_axis_tlast = res.last;

endmodule

// ===== rtl/pbp_checker.sv =====
// ----------------------------------------------------------------------------
// pbp_checker
// Port-level checks on the packet buffer placement top level.
// ----------------------------------------------------------------------------
module pbp_checker
    import pbp_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [127:0] o_m_axis_tdata,
    input logic [2:0]   o_m_axis_tuser,
    input logic         o_m_axis_tlast
);

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while previous item still in work");

    // a too-far-ahead item has no further results
    a_far_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ACT_FAR |-> o_m_axis_tlast)
        else $error("too far ahead result not marked last");

    // drop and carry only on close
    a_close_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ACT_CLOSE |-> o_m_axis_tdata[120:64] == '0)
        else $error("drop or carry field set on a non-close result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind packet_buffer_placement_top pbp_checker u_pbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
